[hw/rtl/lcd4_pkg.sv]
package lcd4_pkg;

    localparam int LCD4_QUEUE_DEPTH = 2;

    localparam logic [15:0] PWR_WAIT_RST   = 16'd15000;
    localparam logic [15:0] CLEAR_HOLD_RST = 16'd1640;
    localparam logic [15:0] SHORT_HOLD_RST = 16'd40;
    localparam logic [15:0] CURSOR_HOLD_RST = 16'd46;

    localparam logic [15:0] HIGH_NIB_HOLD   = 16'd1;
    localparam logic [15:0] INIT_FIRST_HOLD = 16'd4100;
    localparam logic [15:0] INIT_SECOND_HOLD = 16'd100;
    localparam logic [3:0]  INIT_WAKE_NIB   = 4'h3;
    localparam logic [7:0]  CLEAR_BYTE      = 8'h01;
    localparam logic [7:0]  DDRAM_BASE      = 8'h80;
    localparam logic [7:0]  ROW1_OFFSET     = 8'h40;
    localparam logic [3:0]  INIT_LAST_STEP  = 4'd13;
    localparam logic [2:0]  INIT_CLEAR_IDX  = 3'd3;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_PWR_WAIT    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_HOLD  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_HOLD  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_HOLD = 4'd3;

    typedef enum logic [2:0] {
        CMD_INIT   = 3'd0,
        CMD_PRINT  = 3'd1,
        CMD_CLEAR  = 3'd2,
        CMD_CURSOR = 3'd3,
        CMD_RAW    = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [15:0] pwr_wait;
        logic [15:0] clear_hold;
        logic [15:0] short_hold;
        logic [15:0] cursor_hold;
    } t_cfg;

    // One classified request: either the init run or a single byte.
    typedef struct packed {
        logic        is_init;
        logic [7:0]  data;
        logic        rs;
        logic [15:0] hold;
    } t_job;

    // Set-up bytes sent after the two wake-up nibbles.
    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h32;
            3'd1:    b = 8'h28;
            3'd2:    b = 8'h08;
            3'd3:    b = 8'h01;
            3'd4:    b = 8'h06;
            3'd5:    b = 8'h0E;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[hw/rtl/lcd4_front.sv]
module lcd4_front import lcd4_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_data_byte,
    input  logic [5:0]  i_column,
    input  logic        i_row,
    input  logic        i_raw_select,
    input  logic [15:0] i_raw_hold_us,
    input  t_cfg        i_cfg,
    output logic        o_q_push,
    output t_job        o_q_job,
    input  logic        i_q_full
);

    logic r_valid, n_valid;
    t_job r_job, n_job;
    t_job dec_job;
    logic dec_known;
    logic accept;

    assign o_q_push = r_valid & ~i_q_full;
    assign o_q_job  = r_job;
    assign o_full   = r_valid & i_q_full;
    assign accept   = i_push & ~o_full;

    // Classify the request into a byte job or the init run; spare codes are dropped.
    always_comb begin
        dec_job   = '0;
        dec_known = 1'b1;
        unique case (t_cmd'(i_command))
            CMD_INIT: begin
                dec_job.is_init = 1'b1;
            end
            CMD_PRINT: begin
                dec_job.data = i_data_byte;
                dec_job.rs   = 1'b1;
                dec_job.hold = i_cfg.short_hold;
            end
            CMD_CLEAR: begin
                dec_job.data = CLEAR_BYTE;
                dec_job.hold = i_cfg.clear_hold;
            end
            CMD_CURSOR: begin
                dec_job.data = DDRAM_BASE + {2'b00, i_column} + (i_row ? ROW1_OFFSET : 8'h00);
                dec_job.hold = i_cfg.cursor_hold;
            end
            CMD_RAW: begin
                dec_job.data = i_data_byte;
                dec_job.rs   = i_raw_select;
                dec_job.hold = i_raw_hold_us;
            end
            default: begin
                dec_known = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid & ~o_q_push;
        n_job   = r_job;
        if (accept && dec_known) begin
            n_valid = 1'b1;
            n_job   = dec_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_job <= n_job;
    end

endmodule

[hw/rtl/lcd4_queue.sv]
module lcd4_queue import lcd4_pkg::*; #(
    parameter int DEPTH = LCD4_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

[hw/rtl/lcd4_back.sv]
module lcd4_back import lcd4_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_job        i_q_job,
    input  logic        i_q_empty,
    output logic        o_q_pop,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [3:0]  o_nibble,
    output logic        o_reg_select,
    output logic [15:0] o_lead_wait_us,
    output logic [15:0] o_hold_us,
    output logic        o_last
);

    typedef enum logic {
        IDLE,
        RUN
    } t_state;

    t_state      r_state;
    t_job        r_job;
    logic [3:0]  r_step;
    logic        r_out_valid;
    logic [3:0]  r_nibble;
    logic        r_rs;
    logic [15:0] r_lead;
    logic [15:0] r_hold;
    logic        r_last;

    logic [3:0]  s_nib;
    logic        s_rs;
    logic [15:0] s_lead;
    logic [15:0] s_hold;
    logic        s_last;
    logic [3:0]  init_off;
    logic [7:0]  init_b;
    logic        advance;

    assign o_q_pop       = (r_state == IDLE) & ~i_q_empty;
    assign advance       = (r_state == RUN) & (~r_out_valid | i_pop);
    assign o_empty       = ~r_out_valid;
    assign o_nibble      = r_nibble;
    assign o_reg_select  = r_rs;
    assign o_lead_wait_us = r_lead;
    assign o_hold_us     = r_hold;
    assign o_last        = r_last;

    assign init_off = r_step - 4'd2;
    assign init_b   = init_byte(init_off[3:1]);

    // Result for the current step.
    always_comb begin
        s_nib  = '0;
        s_rs   = 1'b0;
        s_lead = '0;
        s_hold = HIGH_NIB_HOLD;
        s_last = 1'b0;
        if (r_job.is_init) begin
            if (r_step == 4'd0) begin
                s_nib  = INIT_WAKE_NIB;
                s_lead = i_cfg.pwr_wait;
                s_hold = INIT_FIRST_HOLD;
            end else if (r_step == 4'd1) begin
                s_nib  = INIT_WAKE_NIB;
                s_hold = INIT_SECOND_HOLD;
            end else if (!init_off[0]) begin
                s_nib = init_b[7:4];
            end else begin
                s_nib  = init_b[3:0];
                s_hold = (init_off[3:1] == INIT_CLEAR_IDX) ? i_cfg.clear_hold
                                                            : i_cfg.short_hold;
                s_last = (r_step == INIT_LAST_STEP);
            end
        end else begin
            s_rs = r_job.rs;
            if (r_step[0]) begin
                s_nib  = r_job.data[3:0];
                s_hold = r_job.hold;
                s_last = 1'b1;
            end else begin
                s_nib = r_job.data[7:4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                IDLE: begin
                    if (o_q_pop) begin
                        r_job   <= i_q_job;
                        r_step  <= '0;
                        r_state <= RUN;
                    end
                end
                RUN: begin
                    if (advance) begin
                        r_out_valid <= 1'b1;
                        r_nibble    <= s_nib;
                        r_rs        <= s_rs;
                        r_lead      <= s_lead;
                        r_hold      <= s_hold;
                        r_last      <= s_last;
                        r_step      <= r_step + 1'b1;
                        if (s_last) begin
                            r_state <= IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= IDLE;
                end
            endcase
        end
    end

endmodule

[hw/rtl/lcd_4bit_command_sequencer.sv]
// Character LCD sequencer for a 4-bit bus. Each request (init, print
// character, clear, move cursor, raw byte) is turned into a run of nibble
// strobes read out like a queue: nibble, RS level, wait before the strobe,
// hold after it, and a last mark on the final nibble. A byte takes two
// results (high nibble with a 1 us hold, then low nibble with the request's
// hold); init takes fourteen. Commands 5 to 7 are taken and produce nothing.
// The front classifies a request into a register and parks it in a
// QUEUE_DEPTH-entry job queue; the back fetches one job when idle and
// steps through its nibbles into an output register as the consumer
// pops, taking the next job only after the last nibble. The
// input accepts new requests while the back is busy until the queue and the
// front register are full. Configuration writes are always ready and must
// be made while the block is idle; indexes beyond the four registers are
// dropped.
module lcd_4bit_command_sequencer import lcd4_pkg::*; #(
    parameter int QUEUE_DEPTH = LCD4_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request side
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [2:0]           i_command,
    input  logic [7:0]           i_data_byte,
    input  logic [5:0]           i_column,
    input  logic                 i_row,
    input  logic                 i_raw_select,
    input  logic [15:0]          i_raw_hold_us,
    // result side
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic [3:0]           o_nibble,
    output logic                 o_reg_select,
    output logic [15:0]          o_lead_wait_us,
    output logic [15:0]          o_hold_us,
    output logic                 o_last,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    t_cfg r_cfg;
    t_job q_in_job, q_out_job;
    logic q_push, q_full, q_pop, q_empty;

    assign o_cfg_ready = 1'b1;

    // Timing registers; hold their value unless a transfer targets them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pwr_wait    <= PWR_WAIT_RST;
            r_cfg.clear_hold  <= CLEAR_HOLD_RST;
            r_cfg.short_hold  <= SHORT_HOLD_RST;
            r_cfg.cursor_hold <= CURSOR_HOLD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PWR_WAIT:    r_cfg.pwr_wait    <= i_cfg_data;
                CFG_CLEAR_HOLD:  r_cfg.clear_hold  <= i_cfg_data;
                CFG_SHORT_HOLD:  r_cfg.short_hold  <= i_cfg_data;
                CFG_CURSOR_HOLD: r_cfg.cursor_hold <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front: accept and classify requests.
    lcd4_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_command    (i_command),
        .i_data_byte  (i_data_byte),
        .i_column     (i_column),
        .i_row        (i_row),
        .i_raw_select (i_raw_select),
        .i_raw_hold_us(i_raw_hold_us),
        .i_cfg        (r_cfg),
        .o_q_push     (q_push),
        .o_q_job      (q_in_job),
        .i_q_full     (q_full)
    );

    // Job queue decouples classification from nibble generation.
    lcd4_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_job  (q_in_job),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_job  (q_out_job),
        .o_empty(q_empty)
    );

    // Back: step through nibbles into the output register.
    lcd4_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_job       (q_out_job),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_nibble      (o_nibble),
        .o_reg_select  (o_reg_select),
        .o_lead_wait_us(o_lead_wait_us),
        .o_hold_us     (o_hold_us),
        .o_last        (o_last)
    );

endmodule

[tb/lcd_4bit_command_sequencer_checker.sv]
`timescale 1ns / 1ps

module lcd_4bit_command_sequencer_checker import lcd4_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic                 i_full,
    input  logic [2:0]           i_command,
    input  logic [7:0]           i_data_byte,
    input  logic [5:0]           i_column,
    input  logic                 i_row,
    input  logic                 i_raw_select,
    input  logic [15:0]          i_raw_hold_us,
    input  logic                 i_empty,
    input  logic                 i_pop,
    input  logic [3:0]           i_nibble,
    input  logic                 i_reg_select,
    input  logic [15:0]          i_lead_wait_us,
    input  logic [15:0]          i_hold_us,
    input  logic                 i_last,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam logic        RS_CMD         = 1'b0;
    localparam logic        RS_DATA        = 1'b1;
    localparam logic [3:0]  WAKE_NIB       = 4'h3;
    localparam logic [15:0] WAKE_HOLD_1    = 16'd4100;
    localparam logic [15:0] WAKE_HOLD_2    = 16'd100;
    localparam logic [15:0] UPPER_HOLD     = 16'd1;
    localparam logic [7:0]  CLEAR_CMD      = 8'h01;
    localparam logic [7:0]  ADDR_BASE      = 8'h80;
    localparam logic [7:0]  ROW2_OFFSET    = 8'h40;
    localparam int          SETUP_LEN      = 6;
    localparam int          SETUP_CLEAR_AT = 3;
    localparam logic [8*SETUP_LEN-1:0] SETUP_SEQ =
        {8'h32, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0E};

    typedef struct packed {
        logic [3:0]  nibble;
        logic        rs;
        logic [15:0] lead;
        logic [15:0] hold;
        logic        last;
    } t_strobe;

    t_strobe     strobe_q[$];
    logic [15:0] pwr_wait_us;
    logic [15:0] clear_hold_us;
    logic [15:0] short_hold_us;
    logic [15:0] cursor_hold_us;
    int          fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    task automatic add_strobe(input logic [3:0] nib, input logic rs, input logic [15:0] lead,
                              input logic [15:0] hold, input logic last_mark);
        t_strobe s;
        s.nibble = nib;
        s.rs     = rs;
        s.lead   = lead;
        s.hold   = hold;
        s.last   = last_mark;
        strobe_q.push_back(s);
    endtask

    // High nibble always holds 1 us; the low nibble carries the request's hold.
    task automatic add_byte(input logic [7:0] b, input logic rs, input logic [15:0] hold,
                            input logic last_mark);
        add_strobe(b[7:4], rs, 16'd0, UPPER_HOLD, 1'b0);
        add_strobe(b[3:0], rs, 16'd0, hold, last_mark);
    endtask

    task automatic predict_request(input logic [2:0] cmd, input logic [7:0] data,
                                   input logic [5:0] column, input logic row,
                                   input logic raw_sel, input logic [15:0] raw_hold);
        logic [7:0] addr;
        addr = ADDR_BASE + {2'b00, column} + (row ? ROW2_OFFSET : 8'h00);
        case (cmd)
            CMD_INIT: begin
                add_strobe(WAKE_NIB, RS_CMD, pwr_wait_us, WAKE_HOLD_1, 1'b0);
                add_strobe(WAKE_NIB, RS_CMD, 16'd0, WAKE_HOLD_2, 1'b0);
                for (int i = 0; i < SETUP_LEN; i++)
                    add_byte(SETUP_SEQ[8*(SETUP_LEN-1-i) +: 8], RS_CMD,
                             (i == SETUP_CLEAR_AT) ? clear_hold_us : short_hold_us,
                             i == SETUP_LEN - 1);
            end
            CMD_PRINT:  add_byte(data, RS_DATA, short_hold_us, 1'b1);
            CMD_CLEAR:  add_byte(CLEAR_CMD, RS_CMD, clear_hold_us, 1'b1);
            CMD_CURSOR: add_byte(addr, RS_CMD, cursor_hold_us, 1'b1);
            CMD_RAW:    add_byte(data, raw_sel, raw_hold, 1'b1);
            default: ;  // spare codes are dropped
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_strobe want;
        if (!i_rst_n) begin
            strobe_q.delete();
            pwr_wait_us    <= 16'd15000;
            clear_hold_us  <= 16'd1640;
            short_hold_us  <= 16'd40;
            cursor_hold_us <= 16'd46;
        end else begin
            if (i_push && !i_full)
                predict_request(i_command, i_data_byte, i_column, i_row,
                                i_raw_select, i_raw_hold_us);
            if (i_pop && !i_empty) begin
                if (strobe_q.size() == 0) begin
                    $error("result transfer with no expected strobe pending");
                    fail_cnt++;
                end else begin
                    want = strobe_q.pop_front();
                    check_field("nibble", 16'(want.nibble), 16'(i_nibble));
                    check_field("reg_select", 16'(want.rs), 16'(i_reg_select));
                    check_field("lead_wait_us", want.lead, i_lead_wait_us);
                    check_field("hold_us", want.hold, i_hold_us);
                    check_field("last", 16'(want.last), 16'(i_last));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PWR_WAIT:    pwr_wait_us    <= i_cfg_data;
                    CFG_CLEAR_HOLD:  clear_hold_us  <= i_cfg_data;
                    CFG_SHORT_HOLD:  short_hold_us  <= i_cfg_data;
                    CFG_CURSOR_HOLD: cursor_hold_us <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending <= strobe_q.size();
    end

endmodule

[tb/tb_lcd_4bit_command_sequencer.sv]
`timescale 1ns / 1ps

module tb_lcd_4bit_command_sequencer import lcd4_pkg::*;;

    // Codes outside the command set; the block takes them and emits nothing.
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam int         CFG_REG_COUNT   = 4;
    localparam int         SEGMENTS        = 4;
    localparam int         ITEMS_PER_SEG   = 70;
    // Slack after the last strobe has been popped.
    localparam int         DRAIN_CYCLES    = 32;
    localparam int         CYCLE_LIMIT     = 400000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;

    logic                 req_push = 1'b0;
    logic                 req_full;
    logic [2:0]           req_command = '0;
    logic [7:0]           req_data = '0;
    logic [5:0]           req_column = '0;
    logic                 req_row = 1'b0;
    logic                 req_raw_sel = 1'b0;
    logic [15:0]          req_raw_hold = '0;

    logic                 res_empty;
    logic                 res_pop = 1'b0;
    logic [3:0]           res_nibble;
    logic                 res_rs;
    logic [15:0]          res_lead;
    logic [15:0]          res_hold;
    logic                 res_last;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;

    int                   fail_count;
    int                   pending;
    int                   cycle_cnt = 0;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    lcd_4bit_command_sequencer u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_push         (req_push),
        .o_full         (req_full),
        .i_command      (req_command),
        .i_data_byte    (req_data),
        .i_column       (req_column),
        .i_row          (req_row),
        .i_raw_select   (req_raw_sel),
        .i_raw_hold_us  (req_raw_hold),
        .o_empty        (res_empty),
        .i_pop          (res_pop),
        .o_nibble       (res_nibble),
        .o_reg_select   (res_rs),
        .o_lead_wait_us (res_lead),
        .o_hold_us      (res_hold),
        .o_last         (res_last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    lcd_4bit_command_sequencer_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_push         (req_push),
        .i_full         (req_full),
        .i_command      (req_command),
        .i_data_byte    (req_data),
        .i_column       (req_column),
        .i_row          (req_row),
        .i_raw_select   (req_raw_sel),
        .i_raw_hold_us  (req_raw_hold),
        .i_empty        (res_empty),
        .i_pop          (res_pop),
        .i_nibble       (res_nibble),
        .i_reg_select   (res_rs),
        .i_lead_wait_us (res_lead),
        .i_hold_us      (res_hold),
        .i_last         (res_last),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Receiver: stall pop at random at the current idle rate; hold it low in reset.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_pop <= 1'b0;
        end else begin
            res_pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_lcd_4bit_command_sequencer failed");
            $finish;
        end
    end

    // Offer one request and hold it until the transfer. Push stays high on return
    // so a back-to-back request needs no second assignment in the same step.
    task automatic send_request(input logic [2:0] cmd, input logic [7:0] data,
                                input logic [5:0] column, input logic row,
                                input logic raw_sel, input logic [15:0] raw_hold);
        while ($urandom_range(99) < send_idle_pct) begin
            req_push <= 1'b0;
            @(posedge clk);
        end
        req_push     <= 1'b1;
        req_command  <= cmd;
        req_data     <= data;
        req_column   <= column;
        req_row      <= row;
        req_raw_sel  <= raw_sel;
        req_raw_hold <= raw_hold;
        @(posedge clk);
        while (req_full) @(posedge clk);
    endtask

    // Drop push and wait until every predicted strobe has been popped, then wait
    // out the drain slack before going on.
    task automatic settle();
        req_push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write; valid stays high so writes can go back to back.
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Program all four timing registers, then poke an unused index that the
    // block must drop without touching any of them.
    task automatic program_timing(input logic [15:0] pwr, input logic [15:0] clr,
                                  input logic [15:0] sht, input logic [15:0] cur);
        put_reg(CFG_PWR_WAIT, pwr);
        put_reg(CFG_CLEAR_HOLD, clr);
        put_reg(CFG_SHORT_HOLD, sht);
        put_reg(CFG_CURSOR_HOLD, cur);
        put_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, CFG_REG_COUNT)),
                16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Random request with random payload; spare codes show up now and then.
    // Return whether the request is one that produces strobes.
    task automatic send_random(output bit counts);
        logic [2:0]  cmd;
        logic [15:0] hold;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            cmd = 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
        end else begin
            cmd = 3'($urandom_range(CMD_RAW, CMD_INIT));
        end
        pick = $urandom_range(99);
        if (pick < 10) begin
            hold = 16'h0000;
        end else if (pick < 20) begin
            hold = 16'hFFFF;
        end else begin
            hold = 16'($urandom);
        end
        send_request(cmd, 8'($urandom), 6'($urandom), 1'($urandom), 1'($urandom), hold);
        counts = (cmd <= CMD_RAW);
    endtask

    initial begin
        int done;
        bit counts;

        // Phase one: slow receiver, lightly idle sender.
        send_idle_pct = 8;
        recv_idle_pct <= 78;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass under the reset timing values.
        send_request(CMD_INIT,   8'h00, 6'd0,  1'b0, 1'b0, 16'h0000);
        send_request(CMD_PRINT,  8'h00, 6'd0,  1'b0, 1'b0, 16'h0000);
        send_request(CMD_PRINT,  8'hFF, 6'd63, 1'b1, 1'b1, 16'hFFFF);
        send_request(CMD_PRINT,  8'h5A, 6'd21, 1'b0, 1'b1, 16'h1234);
        send_request(CMD_CLEAR,  8'hFF, 6'd63, 1'b1, 1'b1, 16'hFFFF);
        // Cursor corners: first and second row, leftmost and rightmost column.
        send_request(CMD_CURSOR, 8'h00, 6'd0,  1'b0, 1'b0, 16'h0000);
        send_request(CMD_CURSOR, 8'hFF, 6'd63, 1'b0, 1'b1, 16'hFFFF);
        send_request(CMD_CURSOR, 8'h00, 6'd0,  1'b1, 1'b0, 16'h0000);
        send_request(CMD_CURSOR, 8'hA5, 6'd63, 1'b1, 1'b0, 16'h0000);
        send_request(CMD_CURSOR, 8'h00, 6'd42, 1'b1, 1'b1, 16'h0000);
        // Raw bytes on both register-select levels, hold extremes.
        send_request(CMD_RAW,    8'h00, 6'd0,  1'b0, 1'b0, 16'h0000);
        send_request(CMD_RAW,    8'hFF, 6'd63, 1'b1, 1'b1, 16'hFFFF);
        send_request(CMD_RAW,    8'hA5, 6'd5,  1'b0, 1'b1, 16'h5A5A);
        send_request(CMD_RAW,    8'h3C, 6'd9,  1'b1, 1'b0, 16'h0001);
        // Spare codes: take them and expect nothing.
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
            send_request(3'(c), 8'($urandom), 6'($urandom), 1'($urandom), 1'($urandom),
                         16'($urandom));
        send_request(CMD_INIT,   8'hFF, 6'd63, 1'b1, 1'b1, 16'hFFFF);
        send_request(CMD_PRINT,  8'hA5, 6'd0,  1'b0, 1'b0, 16'h0000);
        settle();

        // Random segments, each under its own timing: all ones, all zeros,
        // then two random sets. Idle profile shifts as the run goes on.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0: program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: program_timing(16'h0000, 16'h0000, 16'h0000, 16'h0000);
                default: program_timing(16'($urandom), 16'($urandom), 16'($urandom),
                                        16'($urandom));
            endcase
            if (seg == 1) begin
                send_idle_pct = 78;
                recv_idle_pct <= 8;
            end else if (seg >= 2) begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            @(posedge clk);
            done = 0;
            while (done < ITEMS_PER_SEG) begin
                send_random(counts);
                if (counts) done++;
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("tb_lcd_4bit_command_sequencer passed");
        end else begin
            $display("tb_lcd_4bit_command_sequencer failed");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/lcd4_pkg.sv
hw/rtl/lcd4_front.sv
hw/rtl/lcd4_queue.sv
hw/rtl/lcd4_back.sv
hw/rtl/lcd_4bit_command_sequencer.sv
tb/lcd_4bit_command_sequencer_checker.sv
tb/tb_lcd_4bit_command_sequencer.sv
